// ===== sv/kfvi_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator package
// Shared constants, codes, state type and the command/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package kfvi_pkg;

  // Default number of keyframe slots.
  localparam int MAX_KEYS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int TIME_W  = 32;
  localparam int VEC_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int FRAC_W  = 16;
  localparam int ENTRY_W = TIME_W + 3 * VEC_W;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_PAST    = 2'd1;
  localparam logic [1:0] STS_CLAMPED = 2'd2;
  localparam logic [1:0] STS_NO_KEYS = 2'd3;

  // Vector component selects.
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_SRD,
    S_SCMP,
    S_LCMP,
    S_DIV,
    S_MUL,
    S_ADD,
    S_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;    // capture a new item, write the table on a load
    logic       search_rd; // read entry j
    logic       read_lo;   // read entry j-1
    logic       step_j;    // advance the search index
    logic       grab_hi;   // latch the upper key of the segment
    logic       grab_lo;   // latch the lower key and set up the divider
    logic       div_step;  // one quotient bit
    logic       mul;       // multiply the component delta by the factor
    logic       add;       // add to the base and store one component
    logic       zero_out;  // clear the vector outputs
    logic       finish;    // present the result for one cycle
    logic       use_code;  // take the status from code instead of the datapath
    logic [1:0] code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_load;
    logic n_zero;
    logic n_one;
    logic hit;       // query time below the time of the entry just read
    logic last_j;    // search index is at the last key
    logic div_last;
    logic comp_last;
  } stat_t;

endpackage

// ===== sv/kfvi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kfvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/kfvi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences load, key search, division and the per-component blend.
// ----------------------------------------------------------------------------
module kfvi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  kfvi_pkg::stat_t stat_i,
  output kfvi_pkg::cmd_t  cmd_o
);

  kfvi_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfvi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kfvi_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = stat_i.op_load ? kfvi_pkg::S_LOAD : kfvi_pkg::S_CHECK;
        end
      end
      kfvi_pkg::S_LOAD: state_d = kfvi_pkg::S_IDLE;
      kfvi_pkg::S_CHECK: begin
        if (stat_i.n_zero) begin
          state_d = kfvi_pkg::S_IDLE;
        end else if (stat_i.n_one) begin
          state_d = kfvi_pkg::S_LCMP;
        end else begin
          state_d = kfvi_pkg::S_SCMP;
        end
      end
      kfvi_pkg::S_SRD: state_d = kfvi_pkg::S_SCMP;
      kfvi_pkg::S_SCMP: begin
        if (stat_i.hit) begin
          state_d = kfvi_pkg::S_LCMP;
        end else if (stat_i.last_j) begin
          state_d = kfvi_pkg::S_IDLE;
        end else begin
          state_d = kfvi_pkg::S_SRD;
        end
      end
      kfvi_pkg::S_LCMP: begin
        state_d = (stat_i.n_one || stat_i.hit) ? kfvi_pkg::S_MUL : kfvi_pkg::S_DIV;
      end
      kfvi_pkg::S_DIV: begin
        if (stat_i.div_last) begin
          state_d = kfvi_pkg::S_MUL;
        end
      end
      kfvi_pkg::S_MUL: state_d = kfvi_pkg::S_ADD;
      kfvi_pkg::S_ADD: begin
        state_d = stat_i.comp_last ? kfvi_pkg::S_FIN : kfvi_pkg::S_MUL;
      end
      kfvi_pkg::S_FIN: state_d = kfvi_pkg::S_IDLE;
      default: state_d = kfvi_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      kfvi_pkg::S_IDLE: begin
        cmd_o.accept = start_i;
      end
      kfvi_pkg::S_LOAD: begin
        cmd_o.zero_out = 1'b1;
        cmd_o.finish   = 1'b1;
      end
      kfvi_pkg::S_CHECK: begin
        if (stat_i.n_zero) begin
          cmd_o.zero_out = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.use_code = 1'b1;
          cmd_o.code     = kfvi_pkg::STS_NO_KEYS;
        end else if (stat_i.n_one) begin
          cmd_o.read_lo = 1'b1;
        end else begin
          cmd_o.search_rd = 1'b1;
        end
      end
      kfvi_pkg::S_SRD: begin
        cmd_o.search_rd = 1'b1;
      end
      kfvi_pkg::S_SCMP: begin
        if (stat_i.hit) begin
          cmd_o.grab_hi = 1'b1;
          cmd_o.read_lo = 1'b1;
        end else if (stat_i.last_j) begin
          cmd_o.zero_out = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.use_code = 1'b1;
          cmd_o.code     = kfvi_pkg::STS_PAST;
        end else begin
          cmd_o.step_j = 1'b1;
        end
      end
      kfvi_pkg::S_LCMP: cmd_o.grab_lo  = 1'b1;
      kfvi_pkg::S_DIV:  cmd_o.div_step = 1'b1;
      kfvi_pkg::S_MUL:  cmd_o.mul      = 1'b1;
      kfvi_pkg::S_ADD:  cmd_o.add      = 1'b1;
      kfvi_pkg::S_FIN:  cmd_o.finish   = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != kfvi_pkg::S_IDLE);

endmodule

// ===== sv/kfvi_dp.sv =====
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Key table, search index, restoring divider, shared multiplier and the
// result registers.
// ----------------------------------------------------------------------------
module kfvi_dp #(
  parameter int MAX_KEYS = kfvi_pkg::MAX_KEYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kfvi_pkg::cmd_t                      cmd_i,
  output kfvi_pkg::stat_t                     stat_o,
  input  logic                                operation_i,
  input  logic [kfvi_pkg::SLOT_W-1:0]         key_slot_i,
  input  logic [kfvi_pkg::TIME_W-1:0]         key_time_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]   key_x_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]   key_y_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]   key_z_i,
  input  logic [kfvi_pkg::TIME_W-1:0]         query_time_i,
  input  logic                                key_count_we_i,
  input  logic [kfvi_pkg::COUNT_W-1:0]        key_count_wdata_i,
  output logic signed [kfvi_pkg::VEC_W-1:0]   out_x_o,
  output logic signed [kfvi_pkg::VEC_W-1:0]   out_y_o,
  output logic signed [kfvi_pkg::VEC_W-1:0]   out_z_o,
  output logic [1:0]                          status_o,
  output logic                                done_o
);

  localparam int IW   = $clog2(MAX_KEYS);
  localparam int CLW  = $clog2(MAX_KEYS + 1);
  localparam int CW   = (CLW > kfvi_pkg::COUNT_W) ? CLW : kfvi_pkg::COUNT_W;
  localparam int TW   = kfvi_pkg::TIME_W;
  localparam int VW   = kfvi_pkg::VEC_W;
  localparam int FW   = kfvi_pkg::FRAC_W;
  localparam int PW   = VW + 1 + FW + 1;

  // Configuration register and effective key count.
  logic [kfvi_pkg::COUNT_W-1:0] key_count_q;
  logic [CW-1:0]                kc_ext, n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (key_count_we_i) begin
      key_count_q <= key_count_wdata_i;
    end
  end

  assign kc_ext = CW'(key_count_q);
  assign n_eff  = (kc_ext > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_ext;

  // Key table: {time, x, y, z} per entry.
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr, ram_raddr;
  logic [kfvi_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [TW-1:0]                 rd_t;
  logic [VW-1:0]                 rd_x, rd_y, rd_z;
  logic [IW-1:0]                 j_q;

  assign ram_we    = cmd_i.accept && (operation_i == kfvi_pkg::OP_LOAD) &&
                     (32'(key_slot_i) < 32'(MAX_KEYS));
  assign ram_waddr = IW'(key_slot_i);
  assign ram_wdata = {key_time_i, key_x_i, key_y_i, key_z_i};
  assign ram_raddr = cmd_i.read_lo ? (j_q - IW'(1)) : j_q;

  kfvi_ram #(
    .WIDTH (kfvi_pkg::ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_t = ram_rdata[kfvi_pkg::ENTRY_W-1 -: TW];
  assign rd_x = ram_rdata[3*VW-1 -: VW];
  assign rd_y = ram_rdata[2*VW-1 -: VW];
  assign rd_z = ram_rdata[VW-1:0];

  // Query time and search index.
  logic [TW-1:0] qt_q;
  logic          hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.accept) begin
      j_q <= IW'(1);
    end else if (cmd_i.step_j) begin
      j_q <= j_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      qt_q <= query_time_i;
    end
  end

  assign hit = (qt_q < rd_t);

  // Segment endpoints and the restoring divider.
  logic [TW-1:0] thi_q, den_q, rem_q;
  logic [VW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic [FW-1:0] f_q;
  logic [3:0]    dcnt_q;
  logic [TW:0]   rem2, den_ext;
  logic          ge;
  logic [1:0]    st_q;

  assign rem2    = {rem_q, 1'b0};
  assign den_ext = {1'b0, den_q};
  assign ge      = (rem2 >= den_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.grab_hi) begin
      thi_q <= rd_t;
      bx_q  <= rd_x;
      by_q  <= rd_y;
      bz_q  <= rd_z;
    end
    if (cmd_i.grab_lo) begin
      ax_q  <= rd_x;
      ay_q  <= rd_y;
      az_q  <= rd_z;
      rem_q <= qt_q - rd_t;
      den_q <= thi_q - rd_t;
      f_q   <= '0;
      // With one key the upper end equals the lower one.
      if (n_eff == CW'(1)) begin
        bx_q <= rd_x;
        by_q <= rd_y;
        bz_q <= rd_z;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? TW'(rem2 - den_ext) : rem2[TW-1:0];
      f_q   <= {f_q[FW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      st_q   <= kfvi_pkg::STS_OK;
    end else begin
      if (cmd_i.accept) begin
        st_q <= kfvi_pkg::STS_OK;
      end else if (cmd_i.grab_lo) begin
        st_q <= (hit && (n_eff != CW'(1))) ? kfvi_pkg::STS_CLAMPED : kfvi_pkg::STS_OK;
      end
      if (cmd_i.grab_lo) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 4'd1;
      end
    end
  end

  // Shared multiplier and blend, one component at a time.
  logic [1:0]             comp_q;
  logic [VW-1:0]          a_sel, b_sel, blend;
  logic signed [VW:0]     delta;
  logic signed [PW-1:0]   prod_q;

  always_comb begin
    case (comp_q)
      kfvi_pkg::COMP_X: begin
        a_sel = ax_q;
        b_sel = bx_q;
      end
      kfvi_pkg::COMP_Y: begin
        a_sel = ay_q;
        b_sel = by_q;
      end
      default: begin
        a_sel = az_q;
        b_sel = bz_q;
      end
    endcase
  end

  assign delta = $signed({b_sel[VW-1], b_sel}) - $signed({a_sel[VW-1], a_sel});
  // Arithmetic shift by the fraction width floors the scaled delta.
  assign blend = a_sel + prod_q[FW+VW-1:FW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= delta * $signed({1'b0, f_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= kfvi_pkg::COMP_X;
    end else if (cmd_i.accept) begin
      comp_q <= kfvi_pkg::COMP_X;
    end else if (cmd_i.add) begin
      comp_q <= comp_q + 2'd1;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_out) begin
      out_x_o <= '0;
      out_y_o <= '0;
      out_z_o <= '0;
    end else if (cmd_i.add) begin
      case (comp_q)
        kfvi_pkg::COMP_X: out_x_o <= blend;
        kfvi_pkg::COMP_Y: out_y_o <= blend;
        default:          out_z_o <= blend;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o   <= 1'b0;
      status_o <= kfvi_pkg::STS_OK;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_o <= cmd_i.use_code ? cmd_i.code : st_q;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.op_load   = (operation_i == kfvi_pkg::OP_LOAD);
    stat_o.n_zero    = (n_eff == '0);
    stat_o.n_one     = (n_eff == CW'(1));
    stat_o.hit       = hit;
    stat_o.last_j    = ((CW'(j_q) + CW'(1)) == n_eff);
    stat_o.div_last  = (dcnt_q == 4'd15);
    stat_o.comp_last = (comp_q == kfvi_pkg::COMP_Z);
  end

endmodule

// ===== sv/keyframe_vector_interpolator.sv =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator
// Keyframe table with linear search and a Q0.16 linear blend of 3-vectors.
//
//   Channel    Direction  Handshake                Payload
//   command    in         start_i, busy_o          operation_i, key_slot_i,
//                                                  key_time_i, key_x_i..key_z_i,
//                                                  query_time_i
//   result     out        done_o (one-cycle pulse) out_x_o..out_z_o, status_o
//   key count  in         key_count_we_i           key_count_wdata_i
//
// A query scans keys from the start, reading and then comparing one key per
// segment (one table read port, registered), then runs a restoring divider,
// skipped for a clamped query or a single key, and 3 multiply/add pairs on one
// shared multiplier. A command transfer happens when start_i is high and busy_o
// low. Reset is asynchronous, active low, and clears the key count; the table
// contents are kept until written. The receiver cannot stall: each result is
// shown for exactly one cycle.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator #(
  parameter int MAX_KEYS = kfvi_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               operation_i,
  input  logic [kfvi_pkg::SLOT_W-1:0]        key_slot_i,
  input  logic [kfvi_pkg::TIME_W-1:0]        key_time_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]  key_x_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]  key_y_i,
  input  logic signed [kfvi_pkg::VEC_W-1:0]  key_z_i,
  input  logic [kfvi_pkg::TIME_W-1:0]        query_time_i,
  input  logic                               key_count_we_i,
  input  logic [kfvi_pkg::COUNT_W-1:0]       key_count_wdata_i,
  output logic signed [kfvi_pkg::VEC_W-1:0]  out_x_o,
  output logic signed [kfvi_pkg::VEC_W-1:0]  out_y_o,
  output logic signed [kfvi_pkg::VEC_W-1:0]  out_z_o,
  output logic [1:0]                         status_o,
  output logic                               done_o
);

  kfvi_pkg::cmd_t  cmd;
  kfvi_pkg::stat_t stat;

  // Sequencer.
  kfvi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Table, divider, multiplier and result registers.
  kfvi_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .key_slot_i        (key_slot_i),
    .key_time_i        (key_time_i),
    .key_x_i           (key_x_i),
    .key_y_i           (key_y_i),
    .key_z_i           (key_z_i),
    .query_time_i      (query_time_i),
    .key_count_we_i    (key_count_we_i),
    .key_count_wdata_i (key_count_wdata_i),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .out_z_o           (out_z_o),
    .status_o          (status_o),
    .done_o            (done_o)
  );

endmodule
